// ----- sv/u8sv_pkg.sv -----
package u8sv_pkg;

    localparam int          NUM_STATES   = 9;
    localparam int          NUM_CLASSES  = 12;
    localparam int          BUF_DEPTH    = 4;
    localparam logic [3:0]  ST_ACCEPT    = 4'd0;
    localparam logic [3:0]  REJECT_STATE = 4'd1;
    localparam logic [7:0]  REPL_BYTE_0  = 8'hFF;
    localparam logic [7:0]  REPL_BYTE_1  = 8'hFD;

    typedef logic [3:0] t_state;
    typedef logic [3:0] t_class;
    typedef logic [2:0] t_count;

    typedef t_state t_trans_row [NUM_CLASSES];

    localparam t_trans_row TRANS_TAB [NUM_STATES] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
    };

    function automatic t_class byte_class(input logic [7:0] b);
        t_class c;
        if      (b <  8'h80) c = 4'd0;
        else if (b <  8'h90) c = 4'd1;
        else if (b <  8'hA0) c = 4'd9;
        else if (b <  8'hC0) c = 4'd7;
        else if (b <  8'hC2) c = 4'd8;
        else if (b <  8'hE0) c = 4'd2;
        else if (b == 8'hE0) c = 4'd10;
        else if (b == 8'hED) c = 4'd4;
        else if (b <  8'hF0) c = 4'd3;
        else if (b == 8'hF0) c = 4'd11;
        else if (b <  8'hF4) c = 4'd6;
        else if (b == 8'hF4) c = 4'd5;
        else                 c = 4'd8;
        return c;
    endfunction

    function automatic t_state trans_lookup(input t_state st, input t_class cls);
        t_state n;
        if (st < 4'(NUM_STATES) && cls < 4'(NUM_CLASSES)) begin
            n = TRANS_TAB[st][cls];
        end else begin
            n = REJECT_STATE;
        end
        return n;
    endfunction

endpackage

// ----- sv/utf8_sequence_validator_top.sv -----
// UTF-8 sequence validator. One byte is taken per transfer on the input channel,
// one per cycle sustained, and a byte that completes a sequence produces its
// result in the next cycle from the output register. A byte that completes a
// well-formed sequence of 1 to 4 bytes yields that sequence, zero padded, with
// its length; a byte that makes the sequence malformed yields FF FD 00 00 with
// bad_sequence set and the length of the bytes dropped, itself included, and
// decoding restarts at the next byte. Other bytes yield nothing. The byte class
// lookup, the state transition and the buffer update are combinational logic in
// front of the output register; the input side stalls only while a result is
// held and the output side stalls.
module utf8_sequence_validator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_seq_byte_0,
    output logic [7:0] o_seq_byte_1,
    output logic [7:0] o_seq_byte_2,
    output logic [7:0] o_seq_byte_3,
    output logic [2:0] o_seq_length,
    output logic       o_bad_sequence
);
    import u8sv_pkg::*;

    t_state     r_state, n_state;
    logic [7:0] r_buf [BUF_DEPTH];
    logic [7:0] n_buf [BUF_DEPTH];
    t_count     r_count, n_count;

    logic       r_out_valid;
    logic [7:0] r_out_byte [BUF_DEPTH];
    logic [7:0] n_out_byte [BUF_DEPTH];
    t_count     r_out_len;
    logic       r_out_bad, n_out_bad;
    logic       n_emit;

    logic       in_xfer, out_xfer;
    t_state     dfa_next;
    t_count     len;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_xfer    = i_in_valid & ~o_in_stall;
    assign out_xfer   = r_out_valid & ~i_out_stall;

    always_comb begin
        dfa_next = trans_lookup(r_state, byte_class(i_in_byte));
        for (int i = 0; i < BUF_DEPTH; i++) begin
            n_buf[i] = (r_count == 3'(i)) ? i_in_byte : r_buf[i];
        end
        len       = (r_count == 3'd7) ? r_count : r_count + 3'd1;
        n_count   = len;
        n_state   = dfa_next;
        n_emit    = 1'b0;
        n_out_bad = 1'b0;
        n_out_byte = n_buf;
        if (dfa_next == ST_ACCEPT) begin
            n_emit = 1'b1;
        end else if (dfa_next == REJECT_STATE) begin
            n_emit        = 1'b1;
            n_out_bad     = 1'b1;
            n_out_byte[0] = REPL_BYTE_0;
            n_out_byte[1] = REPL_BYTE_1;
            n_out_byte[2] = 8'h00;
            n_out_byte[3] = 8'h00;
            n_state       = ST_ACCEPT;
        end
        if (n_emit) begin
            n_count = '0;
            for (int i = 0; i < BUF_DEPTH; i++) begin
                n_buf[i] = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCEPT;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < BUF_DEPTH; i++) begin
                r_buf[i] <= 8'h00;
            end
        end else begin
            if (in_xfer) begin
                r_state <= n_state;
                r_count <= n_count;
                r_buf   <= n_buf;
            end
            if (in_xfer) begin
                r_out_valid <= n_emit;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && n_emit) begin
            r_out_byte <= n_out_byte;
            r_out_len  <= len;
            r_out_bad  <= n_out_bad;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_seq_byte_0   = r_out_byte[0];
    assign o_seq_byte_1   = r_out_byte[1];
    assign o_seq_byte_2   = r_out_byte[2];
    assign o_seq_byte_3   = r_out_byte[3];
    assign o_seq_length   = r_out_len;
    assign o_bad_sequence = r_out_bad;

endmodule

// ----- tb/sv/utf8_sequence_validator_top_tb.sv -----
`timescale 1ns / 1ps

module utf8_sequence_validator_top_tb;

    import u8sv_pkg::*;

    localparam int RANDOM_BYTES   = 900;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_REPORTS    = 10;

    // decoder states: waiting for the given number of continuation bytes,
    // or for the restricted second byte after E0, ED, F0 and F4
    localparam t_state ST_CONT1 = 4'd2;
    localparam t_state ST_CONT2 = 4'd3;
    localparam t_state ST_E0    = 4'd4;
    localparam t_state ST_ED    = 4'd5;
    localparam t_state ST_F0    = 4'd6;
    localparam t_state ST_CONT3 = 4'd7;
    localparam t_state ST_F4    = 4'd8;

    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      len;
        logic            bad;
    } t_seq_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_in_byte = 8'h00;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_seq_byte_0;
    logic [7:0] o_seq_byte_1;
    logic [7:0] o_seq_byte_2;
    logic [7:0] o_seq_byte_3;
    logic [2:0] o_seq_length;
    logic       o_bad_sequence;

    utf8_sequence_validator_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_seq_byte_0   (o_seq_byte_0),
        .o_seq_byte_1   (o_seq_byte_1),
        .o_seq_byte_2   (o_seq_byte_2),
        .o_seq_byte_3   (o_seq_byte_3),
        .o_seq_length   (o_seq_length),
        .o_bad_sequence (o_bad_sequence)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    logic [7:0]  pending_bytes[$];
    t_seq_result expected_seqs[$];
    int          total_bytes = 0;
    int          bytes_sent = 0;
    int          error_count = 0;

    // decoder shadow
    t_state      dec_state = ST_ACCEPT;
    logic [7:0]  seq_buf [4] = '{default: 8'h00};
    t_count      seq_cnt = '0;

    function automatic t_state next_dec_state(input t_state s, input logic [7:0] b);
        t_state n;
        logic   is_cont;
        is_cont = (b[7:6] == 2'b10);
        n = REJECT_STATE;
        case (s)
            ST_ACCEPT: begin
                if (b < 8'h80) n = ST_ACCEPT;
                else if (b >= 8'hC2 && b <= 8'hDF) n = ST_CONT1;
                else if (b == 8'hE0) n = ST_E0;
                else if (b == 8'hED) n = ST_ED;
                else if (b >= 8'hE1 && b <= 8'hEF) n = ST_CONT2;
                else if (b == 8'hF0) n = ST_F0;
                else if (b >= 8'hF1 && b <= 8'hF3) n = ST_CONT3;
                else if (b == 8'hF4) n = ST_F4;
            end
            ST_CONT1: if (is_cont) n = ST_ACCEPT;
            ST_CONT2: if (is_cont) n = ST_CONT1;
            ST_CONT3: if (is_cont) n = ST_CONT2;
            ST_E0:    if (b >= 8'hA0 && b <= 8'hBF) n = ST_CONT1;
            ST_ED:    if (b >= 8'h80 && b <= 8'h9F) n = ST_CONT1;
            ST_F0:    if (b >= 8'h90 && b <= 8'hBF) n = ST_CONT2;
            ST_F4:    if (b >= 8'h80 && b <= 8'h8F) n = ST_CONT2;
            default:  n = REJECT_STATE;
        endcase
        return n;
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        t_state      nxt;
        t_seq_result r;
        nxt = next_dec_state(dec_state, b);
        if (seq_cnt < 3'(BUF_DEPTH)) seq_buf[seq_cnt[1:0]] = b;
        seq_cnt = seq_cnt + 3'd1;
        if (nxt == ST_ACCEPT || nxt == REJECT_STATE) begin
            r.len = seq_cnt;
            r.bad = (nxt == REJECT_STATE);
            if (r.bad) begin
                r.data = {8'h00, 8'h00, REPL_BYTE_1, REPL_BYTE_0};
            end else begin
                r.data = {seq_buf[3], seq_buf[2], seq_buf[1], seq_buf[0]};
            end
            expected_seqs.push_back(r);
            seq_buf = '{default: 8'h00};
            seq_cnt = '0;
            dec_state = ST_ACCEPT;
        end else begin
            dec_state = nxt;
        end
    endtask

    task automatic report_error(input string msg);
        if (error_count < MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // random well-formed character of n bytes, left aligned
    function automatic logic [31:0] encode_char(input int n);
        logic [20:0] cp;
        logic [31:0] w;
        case (n)
            1: begin
                cp = 21'($urandom_range(0, 'h7F));
                w = {cp[7:0], 24'h0};
            end
            2: begin
                cp = 21'($urandom_range('h80, 'h7FF));
                w = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
            end
            3: begin
                cp = 21'($urandom_range('h800, 'hF7FF));
                if (cp >= 21'hD800) cp = cp + 21'h800;
                w = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
            end
            default: begin
                cp = 21'($urandom_range('h10000, 'h10FFFF));
                w = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
            end
        endcase
        return w;
    endfunction

    task automatic push_bytes(input logic [31:0] w, input int n);
        for (int i = 0; i < n; i++) pending_bytes.push_back(w[31 - 8 * i -: 8]);
    endtask

    // input driver
    logic in_burst = 1'b0;
    int   in_gap = 0;

    always @(posedge i_clk) begin
        logic       nv;
        logic [7:0] nb;
        nv = i_in_valid;
        nb = i_in_byte;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                decode_byte(i_in_byte);
                bytes_sent++;
                nv = 1'b0;
                if ($urandom_range(0, 49) == 0) in_burst = !in_burst;
                in_gap = in_burst ? 0 : $urandom_range(0, 16);
            end
            if (!nv) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_bytes.size() > 0) begin
                    nv = 1'b1;
                    nb = pending_bytes.pop_front();
                end
            end
        end
        i_in_valid <= nv;
        i_in_byte  <= nb;
    end

    // long receiver hold-off so the block fills and stalls its input
    logic hold_off = 1'b0;
    int   hold_cnt = 0;
    int   run_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            run_cycles++;
            if (hold_cnt > 0) begin
                hold_cnt--;
            end else if (run_cycles == 1500 || run_cycles == 4000) begin
                hold_cnt = HOLD_CYCLES;
            end
        end
        hold_off <= (hold_cnt > 0);
    end

    // output monitor
    logic out_burst = 1'b0;
    int   out_wait = 0;

    always @(posedge i_clk) begin
        logic        ns;
        t_seq_result got;
        t_seq_result want;
        ns = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got.data = {o_seq_byte_3, o_seq_byte_2, o_seq_byte_1, o_seq_byte_0};
                got.len  = o_seq_length;
                got.bad  = o_bad_sequence;
                if (expected_seqs.size() == 0) begin
                    report_error($sformatf("unexpected transfer %h len %0d bad %0b",
                                           got.data, got.len, got.bad));
                end else begin
                    want = expected_seqs.pop_front();
                    if (got !== want) begin
                        report_error($sformatf(
                            "expected %h len %0d bad %0b, got %h len %0d bad %0b",
                            want.data, want.len, want.bad, got.data, got.len, got.bad));
                    end
                end
                if ($urandom_range(0, 49) == 0) out_burst = !out_burst;
                out_wait = out_burst ? 0 : $urandom_range(0, 16);
            end
            if (out_wait > 0) begin
                ns = 1'b1;
                out_wait--;
            end
            if (hold_off) ns = 1'b1;
        end
        i_out_stall <= ns;
    end

    // watchdog on cycles without any transfer
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("utf8_sequence_validator_top_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0]  directed [];
        logic [31:0] w;
        int          n;
        int          cut;
        int          pick;
        directed = '{
            8'h00, 8'h7F,
            8'hC2, 8'h80,
            8'hE0, 8'hA0, 8'h80,
            8'hED, 8'h9F, 8'hBF,
            8'hF0, 8'h90, 8'h80, 8'h80,
            8'hF4, 8'h8F, 8'hBF, 8'hBF,
            8'h80, 8'hC0, 8'hFF,
            8'hE0, 8'h80,
            8'hED, 8'hA0,
            8'hC2, 8'h41
        };
        foreach (directed[i]) pending_bytes.push_back(directed[i]);
        while (pending_bytes.size() < directed.size() + RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                n = $urandom_range(1, 4);
                push_bytes(encode_char(n), n);
            end else if (pick < 88) begin
                pending_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 95) begin
                // truncated sequence
                n = $urandom_range(2, 4);
                push_bytes(encode_char(n), $urandom_range(1, n - 1));
            end else begin
                // one continuation byte replaced by a random byte
                n = $urandom_range(2, 4);
                w = encode_char(n);
                cut = $urandom_range(1, n - 1);
                w[31 - 8 * cut -: 8] = 8'($urandom_range(0, 255));
                push_bytes(w, n);
            end
        end
        total_bytes = pending_bytes.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_sent < total_bytes || expected_seqs.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("utf8_sequence_validator_top_tb OK");
        end else begin
            $display("utf8_sequence_validator_top_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/u8sv_pkg.sv
sv/utf8_sequence_validator_top.sv
tb/sv/utf8_sequence_validator_top_tb.sv
